// ----- src/ptfc_pkg.sv -----
// ============================================================================
// ptfc_pkg: shared types and constants for the joint PID torque controller
// Field widths, mode and register codes, sequencer states and result record.
// ============================================================================
package ptfc_pkg;

    localparam int JOINTS_DEF = 3;

    localparam int MODE_W  = 2;
    localparam int JIDX_W  = 2;
    localparam int DATA_W  = 32;
    localparam int GAIN_W  = 31;
    localparam int TICK_W  = 16;
    localparam int CNT_W   = 32;
    localparam int INTEG_W = 48;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: 33 x 33 signed
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W  = 64;

    localparam logic [GAIN_W-1:0] CEIL_RST = 31'd65536;
    localparam logic [TICK_W-1:0] TICK_RST = 16'd66;

    typedef enum logic [MODE_W-1:0] {
        MODE_STEP      = 2'd0,
        MODE_CLR_INTEG = 2'd1,
        MODE_CLR_CNT   = 2'd2,
        MODE_RSVD      = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KI   = 3'd1,
        CFG_KD   = 3'd2,
        CFG_KA   = 3'd3,
        CFG_CEIL = 3'd4,
        CFG_TICK = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_SAT,
        S_CMP,
        S_DONE
    } t_state;

    // Multiplier issue slots; all but ST_TICK also retire the prior slot's product
    typedef enum logic [2:0] {
        ST_TICK  = 3'd0,
        ST_KP    = 3'd1,
        ST_KD    = 3'd2,
        ST_KA    = 3'd3,
        ST_KI_HI = 3'd4,
        ST_KI_LO = 3'd5,
        ST_DRAIN = 3'd6
    } t_step;

    typedef struct packed {
        logic [JIDX_W-1:0]        joint_echo;
        logic signed [DATA_W-1:0] torque_command;
        logic signed [DATA_W-1:0] torque_unclamped;
        logic                     at_limit;
        logic [CNT_W-1:0]         limit_hits;
    } t_res;

endpackage

// ----- src/ptfc_cmd_if.sv -----
// ============================================================================
// ptfc_cmd_if: command channel of the joint PID torque controller
// Valid/ready handshake with one control item per transfer.
// ============================================================================
interface ptfc_cmd_if import ptfc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic [JIDX_W-1:0]        joint_index;
    logic signed [DATA_W-1:0] measured_position;
    logic signed [DATA_W-1:0] measured_velocity;
    logic signed [DATA_W-1:0] target_position;
    logic signed [DATA_W-1:0] target_velocity;
    logic signed [DATA_W-1:0] target_acceleration;

    modport source (
        output valid, mode, joint_index, measured_position, measured_velocity,
               target_position, target_velocity, target_acceleration,
        input  ready
    );

    modport sink (
        input  valid, mode, joint_index, measured_position, measured_velocity,
               target_position, target_velocity, target_acceleration,
        output ready
    );
endinterface

// ----- src/ptfc_res_if.sv -----
// ============================================================================
// ptfc_res_if: result channel of the joint PID torque controller
// Valid/ready handshake with one result item per transfer.
// ============================================================================
interface ptfc_res_if import ptfc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [JIDX_W-1:0]        joint_echo;
    logic signed [DATA_W-1:0] torque_command;
    logic signed [DATA_W-1:0] torque_unclamped;
    logic                     at_limit;
    logic [CNT_W-1:0]         limit_hits;

    modport source (
        output valid, joint_echo, torque_command, torque_unclamped, at_limit, limit_hits,
        input  ready
    );

    modport sink (
        input  valid, joint_echo, torque_command, torque_unclamped, at_limit, limit_hits,
        output ready
    );
endinterface

// ----- src/pid_torque_with_feedforward_clamp_top.sv -----
// ============================================================================
// pid_torque_with_feedforward_clamp_top: per-joint PID torque with feedforward
// Q16.16 PID plus acceleration feedforward, 48-bit saturating integral,
// 32-bit saturation, symmetric clamp and per-joint limit hit counters.
// ============================================================================
//
//  channel   dir  handshake            payload
//  i_cmd     in   valid/ready          mode, joint_index, measured/target state
//  o_res     out  valid/ready          joint_echo, torques, at_limit, limit_hits
//  i_cfg_*   in   write enable only    register index, 31-bit data
//
//  A control step goes from accept to the output register via decode, the
//  single 33x33 multiplier (slots tick, kp, kd, ka, ki high, ki low, drain;
//  six products, one retire per cycle), saturate/clamp, limit compare and
//  handoff. Clear and reserved modes skip to handoff. One item is in flight
//  at a time. The output register holds a result while o_res stalls; the
//  next item is accepted and worked on, waiting in the handoff state until
//  that slot frees. Reset (i_rst_n low, synchronous) clears gains, integrals
//  and counters; no clearing pass.
//
module pid_torque_with_feedforward_clamp_top
    import ptfc_pkg::*;
#(
    parameter int JOINTS = JOINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    ptfc_cmd_if.sink             i_cmd,
    ptfc_res_if.source           o_res
);

    localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = 48'sh8000_0000_0000;
    localparam logic signed [DATA_W-1:0]  SAT_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0]  SAT_MIN   = 32'sh8000_0000;

    // Configuration
    logic [GAIN_W-1:0] r_kp, r_ki, r_kd, r_ka, r_ceil;
    logic [TICK_W-1:0] r_tick;

    // Per-joint state
    logic signed [INTEG_W-1:0] r_integ_mem [JOINTS];
    logic signed [INTEG_W-1:0] n_integ_mem [JOINTS];
    logic [CNT_W-1:0]          r_cnt [JOINTS];
    logic [CNT_W-1:0]          n_cnt [JOINTS];

    // Sequencer and datapath
    t_state                    r_state, n_state;
    t_step                     r_step, n_step;
    t_mode                     r_mode, n_mode;
    logic [JIDX_W-1:0]         r_joint, n_joint;
    logic signed [MUL_W-1:0]   r_e, n_e;
    logic signed [MUL_W-1:0]   r_ev, n_ev;
    logic signed [DATA_W-1:0]  r_accel, n_accel;
    logic signed [INTEG_W-1:0] r_integ, n_integ;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [DATA_W-1:0]  r_raw, n_raw;
    logic signed [DATA_W-1:0]  r_cmd, n_cmd;
    t_res                      r_res, n_res;
    t_res                      r_out, n_out;
    logic                      r_out_vld, n_out_vld;

    // Combinational helpers
    logic                      w_jok;
    logic [JW-1:0]             w_jsel;
    logic signed [MUL_W-1:0]   w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_prod_fl;
    logic signed [INTEG_W+1:0] w_isum;
    logic signed [INTEG_W-1:0] w_isat;
    logic signed [DATA_W-1:0]  w_sat32;
    logic signed [DATA_W-1:0]  w_lim, w_nlim;
    logic [DATA_W-1:0]         w_mag;
    logic [DATA_W+5:0]         w_mag50, w_ceil49;
    logic                      w_hit;
    logic [CNT_W-1:0]          w_cnt_cur;

    assign w_jok  = ({3'b000, r_joint} < 5'(JOINTS));
    assign w_jsel = JW'(r_joint);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= '0;
            r_ki   <= '0;
            r_kd   <= '0;
            r_ka   <= '0;
            r_ceil <= CEIL_RST;
            r_tick <= TICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KP:   r_kp   <= i_cfg_data;
                CFG_KI:   r_ki   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                CFG_KA:   r_ka   <= i_cfg_data;
                CFG_CEIL: r_ceil <= i_cfg_data;
                CFG_TICK: r_tick <= i_cfg_data[TICK_W-1:0];
                default:  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------
    always_comb begin
        case (r_step)
            ST_TICK: begin
                w_mul_a = r_e;
                w_mul_b = $signed({17'd0, r_tick});
            end
            ST_KP: begin
                w_mul_a = r_e;
                w_mul_b = $signed({2'b00, r_kp});
            end
            ST_KD: begin
                w_mul_a = r_ev;
                w_mul_b = $signed({2'b00, r_kd});
            end
            ST_KA: begin
                w_mul_a = MUL_W'(r_accel);
                w_mul_b = $signed({2'b00, r_ka});
            end
            ST_KI_HI: begin
                // integer part of the integral, floor(integ / 2^16)
                w_mul_a = MUL_W'($signed(r_integ[INTEG_W-1:16]));
                w_mul_b = $signed({2'b00, r_ki});
            end
            ST_KI_LO: begin
                w_mul_a = $signed({17'd0, r_integ[15:0]});
                w_mul_b = $signed({2'b00, r_ki});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_prod_fl = r_prod >>> 16;

    // Integral update from the tick product
    assign w_cnt_cur = r_cnt[w_jsel];
    assign w_isum    = (INTEG_W+2)'(r_integ_mem[w_jsel]) + w_prod_fl[INTEG_W+1:0];
    always_comb begin
        if (w_isum[INTEG_W+1:INTEG_W-1] == 3'b000 || w_isum[INTEG_W+1:INTEG_W-1] == 3'b111) begin
            w_isat = w_isum[INTEG_W-1:0];
        end else if (w_isum[INTEG_W+1]) begin
            w_isat = INTEG_MIN;
        end else begin
            w_isat = INTEG_MAX;
        end
    end

    // Saturate the sum to 32 bits, then clamp to the ceiling
    always_comb begin
        if (r_sum[SUM_W-1:DATA_W-1] == '0 || r_sum[SUM_W-1:DATA_W-1] == '1) begin
            w_sat32 = r_sum[DATA_W-1:0];
        end else if (r_sum[SUM_W-1]) begin
            w_sat32 = SAT_MIN;
        end else begin
            w_sat32 = SAT_MAX;
        end
    end
    assign w_lim  = $signed({1'b0, r_ceil});
    assign w_nlim = -w_lim;

    // |cmd| * 50 >= ceiling * 49, built from shifts
    assign w_mag    = r_cmd[DATA_W-1] ? DATA_W'(-r_cmd) : DATA_W'(r_cmd);
    assign w_mag50  = {w_mag, 5'b0} + {1'b0, w_mag, 4'b0} + {4'b0, w_mag, 1'b0};
    assign w_ceil49 = {1'b0, r_ceil, 5'b0} + {2'b0, r_ceil, 4'b0} + {6'b0, r_ceil};
    assign w_hit    = (w_mag50 >= w_ceil49);

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_mode      = r_mode;
        n_joint     = r_joint;
        n_e         = r_e;
        n_ev        = r_ev;
        n_accel     = r_accel;
        n_integ     = r_integ;
        n_prod      = r_prod;
        n_sum       = r_sum;
        n_raw       = r_raw;
        n_cmd       = r_cmd;
        n_res       = r_res;
        n_out       = r_out;
        n_out_vld   = r_out_vld;
        n_integ_mem = r_integ_mem;
        n_cnt       = r_cnt;
        i_cmd.ready = (r_state == S_IDLE);

        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_mode  = t_mode'(i_cmd.mode);
                    n_joint = i_cmd.joint_index;
                    n_e     = MUL_W'(i_cmd.target_position) - MUL_W'(i_cmd.measured_position);
                    n_ev    = MUL_W'(i_cmd.target_velocity) - MUL_W'(i_cmd.measured_velocity);
                    n_accel = i_cmd.target_acceleration;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res            = '0;
                n_res.joint_echo = r_joint;
                n_state          = S_DONE;
                if (r_mode == MODE_CLR_CNT) begin
                    for (int j = 0; j < JOINTS; j++) begin
                        n_cnt[j] = '0;
                    end
                end else if (w_jok) begin
                    case (r_mode)
                        MODE_CLR_INTEG: begin
                            n_integ_mem[w_jsel] = '0;
                            n_res.limit_hits    = w_cnt_cur;
                        end
                        MODE_RSVD: begin
                            n_res.limit_hits = w_cnt_cur;
                        end
                        MODE_STEP: begin
                            n_step  = ST_TICK;
                            n_sum   = '0;
                            n_state = S_MUL;
                        end
                        default: ;
                    endcase
                end
            end

            S_MUL: begin
                n_prod = w_prod;
                // retire the product issued in the previous slot
                case (r_step)
                    ST_KP: begin
                        n_integ             = w_isat;
                        n_integ_mem[w_jsel] = w_isat;
                    end
                    ST_KD, ST_KA, ST_KI_HI, ST_DRAIN: begin
                        n_sum = r_sum + w_prod_fl[SUM_W-1:0];
                    end
                    ST_KI_LO: begin
                        // integer-part product carries no fraction to drop
                        n_sum = r_sum + r_prod[SUM_W-1:0];
                    end
                    default: ;
                endcase
                if (r_step == ST_DRAIN) begin
                    n_state = S_SAT;
                end else begin
                    n_step = t_step'(r_step + 3'd1);
                end
            end

            S_SAT: begin
                n_raw = w_sat32;
                if (w_sat32 > w_lim) begin
                    n_cmd = w_lim;
                end else if (w_sat32 < w_nlim) begin
                    n_cmd = w_nlim;
                end else begin
                    n_cmd = w_sat32;
                end
                n_state = S_CMP;
            end

            S_CMP: begin
                n_res.joint_echo       = r_joint;
                n_res.torque_command   = r_cmd;
                n_res.torque_unclamped = r_raw;
                n_res.at_limit         = w_hit;
                n_res.limit_hits       = w_cnt_cur;
                if (w_hit && w_cnt_cur != '1) begin
                    n_cnt[w_jsel]    = w_cnt_cur + 32'd1;
                    n_res.limit_hits = w_cnt_cur + 32'd1;
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= ST_TICK;
            r_out_vld <= 1'b0;
            for (int j = 0; j < JOINTS; j++) begin
                r_integ_mem[j] <= '0;
                r_cnt[j]       <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_vld   <= n_out_vld;
            r_integ_mem <= n_integ_mem;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_joint <= n_joint;
        r_e     <= n_e;
        r_ev    <= n_ev;
        r_accel <= n_accel;
        r_integ <= n_integ;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_raw   <= n_raw;
        r_cmd   <= n_cmd;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.joint_echo       = r_out.joint_echo;
    assign o_res.torque_command   = r_out.torque_command;
    assign o_res.torque_unclamped = r_out.torque_unclamped;
    assign o_res.at_limit         = r_out.at_limit;
    assign o_res.limit_hits       = r_out.limit_hits;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while an item is in flight");

    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.at_limit) |-> (o_res.limit_hits != '0))
        else $error("limit flagged without a counted hit");

    a_cmd_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.torque_command <= w_lim && o_res.torque_command >= w_nlim))
        else $error("torque command outside the ceiling");

    a_step_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_mode == MODE_STEP && w_jok))
        else $error("multiplier sequence run for a non-step item");

endmodule

// ----- tb/ptfc_torque_check_pkg.sv -----
// ============================================================================
// ptfc_torque_check_pkg: torque predictor and result checker for the joint PID
// Tracks gains, per-joint integrals and hit counters, predicts one result per
// command item and compares results from the block field by field, in order.
// ============================================================================
package ptfc_torque_check_pkg;

    import ptfc_pkg::*;

    typedef struct packed {
        t_mode                    mode;
        logic [JIDX_W-1:0]        joint;
        logic signed [DATA_W-1:0] mpos;
        logic signed [DATA_W-1:0] mvel;
        logic signed [DATA_W-1:0] tpos;
        logic signed [DATA_W-1:0] tvel;
        logic signed [DATA_W-1:0] tacc;
    } t_joint_cmd;

    localparam longint INTEG_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    localparam longint TORQUE_MAX = 64'sd2147483647;
    localparam longint TORQUE_MIN = -TORQUE_MAX - 1;

    class joint_torque_checker;
        logic [GAIN_W-1:0] kp, ki, kd, ka, ceiling;
        logic [TICK_W-1:0] tick;
        longint            integral_q [JOINTS_DEF];
        logic [CNT_W-1:0]  hit_count [JOINTS_DEF];
        t_res              pending_torques [$];
        int                mismatches;
        int                n_steps, n_clears, n_other, n_at_limit;

        function new();
            kp = '0;
            ki = '0;
            kd = '0;
            ka = '0;
            ceiling = CEIL_RST;
            tick = TICK_RST;
            foreach (integral_q[k]) integral_q[k] = 0;
            foreach (hit_count[k]) hit_count[k] = '0;
            mismatches = 0;
            n_steps = 0;
            n_clears = 0;
            n_other = 0;
            n_at_limit = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [GAIN_W-1:0] d);
            case (idx)
                CFG_KP:   kp = d;
                CFG_KI:   ki = d;
                CFG_KD:   kd = d;
                CFG_KA:   ka = d;
                CFG_CEIL: ceiling = d;
                CFG_TICK: tick = d[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function t_res predict_torque(t_joint_cmd c);
            t_res   r;
            int     j;
            longint e, ev, acc, integ, hi, lo, total, cmd, lim, mag;
            r = '0;
            r.joint_echo = c.joint;
            if (c.mode == MODE_CLR_CNT) begin
                foreach (hit_count[k]) hit_count[k] = '0;
                n_clears++;
                return r;
            end
            if (c.joint >= JOINTS_DEF) begin
                n_other++;
                return r;
            end
            j = int'(c.joint);
            if (c.mode == MODE_CLR_INTEG) begin
                integral_q[j] = 0;
                r.limit_hits = hit_count[j];
                n_clears++;
                return r;
            end
            if (c.mode == MODE_RSVD) begin
                r.limit_hits = hit_count[j];
                n_other++;
                return r;
            end
            n_steps++;
            e   = longint'($signed(c.tpos)) - longint'($signed(c.mpos));
            ev  = longint'($signed(c.tvel)) - longint'($signed(c.mvel));
            acc = longint'($signed(c.tacc));

            integ = integral_q[j] + ((e * longint'(tick)) >>> 16);
            if (integ > INTEG_MAX) integ = INTEG_MAX;
            else if (integ < INTEG_MIN) integ = INTEG_MIN;
            integral_q[j] = integ;

            // integral term split so ki * integral stays inside 64 bits
            hi = integ >>> 16;
            lo = integ - hi * 65536;
            total = ((longint'(kp) * e) >>> 16) + ((longint'(kd) * ev) >>> 16)
                  + ((longint'(ka) * acc) >>> 16) + longint'(ki) * hi
                  + ((longint'(ki) * lo) >>> 16);
            if (total > TORQUE_MAX) total = TORQUE_MAX;
            else if (total < TORQUE_MIN) total = TORQUE_MIN;

            lim = longint'(ceiling);
            cmd = total;
            if (cmd > lim) cmd = lim;
            if (cmd < -lim) cmd = -lim;
            mag = (cmd < 0) ? -cmd : cmd;

            r.torque_command   = cmd[DATA_W-1:0];
            r.torque_unclamped = total[DATA_W-1:0];
            if (mag * 50 >= lim * 49) begin
                r.at_limit = 1'b1;
                n_at_limit++;
                if (hit_count[j] != '1) hit_count[j]++;
            end
            r.limit_hits = hit_count[j];
            return r;
        endfunction

        function void note_command(t_joint_cmd c);
            t_res r;
            r = predict_torque(c);
            pending_torques.insert(pending_torques.size(), r);
        endfunction

        function int outstanding();
            return pending_torques.size();
        endfunction

        function void compare_field(string fname, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $error("%s: expected 'h%0h, got 'h%0h", fname, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_torques.size() == 0) begin
                mismatches++;
                $error("result for joint %0d arrived with no item pending", got.joint_echo);
                return;
            end
            want = pending_torques.pop_front();
            compare_field("joint_echo", CNT_W'(want.joint_echo), CNT_W'(got.joint_echo));
            compare_field("torque_command", want.torque_command, got.torque_command);
            compare_field("torque_unclamped", want.torque_unclamped, got.torque_unclamped);
            compare_field("at_limit", CNT_W'(want.at_limit), CNT_W'(got.at_limit));
            compare_field("limit_hits", want.limit_hits, got.limit_hits);
        endfunction
    endclass

endpackage

// ----- tb/pid_torque_with_feedforward_clamp_top_test.sv -----
// ============================================================================
// pid_torque_with_feedforward_clamp_top_test: testbench for the joint PID
// Directed corner items, several random gain/ceiling settings with random
// handshake gaps and a long output stall, then an integral wind-up run.
// ============================================================================
module pid_torque_with_feedforward_clamp_top_test;

    import ptfc_pkg::*;
    import ptfc_torque_check_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          DRAIN_CYCLES  = 30;
    localparam int          RAND_SETTINGS = 6;
    localparam int          RAND_ITEMS    = 150;
    // steps per joint at full error and tick in the closing gap-free run
    localparam int          WINDUP_STEPS  = 16;

    localparam logic [GAIN_W-1:0]        GAIN_MAX = '1;
    localparam logic [GAIN_W-1:0]        ONE_Q16  = 31'd65536;
    localparam logic [TICK_W-1:0]        TICK_MAX = '1;
    localparam logic signed [DATA_W-1:0] Q_MAX32  = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN32  = 32'sh8000_0000;
    localparam logic [JIDX_W-1:0]        JOINT_OOR = JIDX_W'(JOINTS_DEF);

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;

    ptfc_cmd_if cmd_if ();
    ptfc_res_if res_if ();

    pid_torque_with_feedforward_clamp_top #(
        .JOINTS(JOINTS_DEF)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    joint_torque_checker torque_chk = new();

    bit calm;       // no gaps on either side
    bit hold_req;   // result side stalls for HOLD_CYCLES
    int n_settings;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Random value helpers
    // ------------------------------------------------------------------------
    function automatic logic signed [DATA_W-1:0] pick_small();
        return int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_q16();
        case ($urandom_range(0, 9))
            0:       return Q_MAX32;
            1:       return Q_MIN32;
            2, 3:    return $urandom;
            default: return int'($urandom_range(0, 128 * 65536)) - 64 * 65536;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_MAX;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 4 * 65536));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_ceiling();
        case ($urandom_range(0, 5))
            0:       return GAIN_MAX;
            1:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1, 64 * 65536));
        endcase
    endfunction

    function automatic logic [TICK_W-1:0] pick_tick();
        case ($urandom_range(0, 5))
            0:       return TICK_MAX;
            1:       return 16'd1;
            default: return TICK_W'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic t_joint_cmd make_cmd(t_mode m, logic [JIDX_W-1:0] j,
                                            logic signed [DATA_W-1:0] mp, mv, tp, tv, ta);
        t_joint_cmd c;
        c.mode  = m;
        c.joint = j;
        c.mpos  = mp;
        c.mvel  = mv;
        c.tpos  = tp;
        c.tvel  = tv;
        c.tacc  = ta;
        return c;
    endfunction

    // Mostly control steps that track the target closely, plus clears and noise
    function automatic t_joint_cmd random_cmd();
        t_joint_cmd  c;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 82) c.mode = MODE_STEP;
        else if (roll < 90) c.mode = MODE_CLR_INTEG;
        else if (roll < 95) c.mode = MODE_RSVD;
        else c.mode = MODE_CLR_CNT;
        c.joint = ($urandom_range(0, 19) == 0) ? JOINT_OOR
                                                : JIDX_W'($urandom_range(0, JOINTS_DEF - 1));
        c.mpos = pick_q16();
        c.mvel = pick_q16();
        c.tacc = pick_q16();
        c.tpos = ($urandom_range(0, 4) != 0) ? c.mpos + pick_small() : pick_q16();
        c.tvel = ($urandom_range(0, 4) != 0) ? c.mvel + pick_small() : pick_q16();
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_cmd(input t_joint_cmd c);
        cmd_if.valid               <= 1'b1;
        cmd_if.mode                <= c.mode;
        cmd_if.joint_index         <= c.joint;
        cmd_if.measured_position   <= c.mpos;
        cmd_if.measured_velocity   <= c.mvel;
        cmd_if.target_position     <= c.tpos;
        cmd_if.target_velocity     <= c.tvel;
        cmd_if.target_acceleration <= c.tacc;
        do @(posedge i_clk); while (!cmd_if.ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (torque_chk.outstanding() != 0);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [GAIN_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        torque_chk.set_register(idx, d);
        @(posedge i_clk);
    endtask

    task automatic write_config(input logic [GAIN_W-1:0] kp, ki, kd, ka, ceil,
                                input logic [TICK_W-1:0] tick_len);
        put_reg(CFG_KP, kp);
        put_reg(CFG_KI, ki);
        put_reg(CFG_KD, kd);
        put_reg(CFG_KA, ka);
        put_reg(CFG_CEIL, ceil);
        // upper data bits are don't-care for the tick register
        put_reg(CFG_TICK, {(GAIN_W - TICK_W)'($urandom), tick_len});
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Result side ready: random bursts, one long hold, steady when calm
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int n;
        bit level;
        res_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                level = ($urandom_range(0, 2) != 0);
                n = level ? $urandom_range(1, 24) : $urandom_range(1, 12);
                res_if.ready <= level;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Check results before noting inputs: a result never belongs to an item
    // accepted at the same edge.
    always @(posedge i_clk) begin
        t_res       got;
        t_joint_cmd c;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.joint_echo       = res_if.joint_echo;
                got.torque_command   = res_if.torque_command;
                got.torque_unclamped = res_if.torque_unclamped;
                got.at_limit         = res_if.at_limit;
                got.limit_hits       = res_if.limit_hits;
                torque_chk.check_result(got);
            end
            if (cmd_if.valid && cmd_if.ready) begin
                c.mode  = t_mode'(cmd_if.mode);
                c.joint = cmd_if.joint_index;
                c.mpos  = cmd_if.measured_position;
                c.mvel  = cmd_if.measured_velocity;
                c.tpos  = cmd_if.target_position;
                c.tvel  = cmd_if.target_velocity;
                c.tacc  = cmd_if.target_acceleration;
                torque_chk.note_command(c);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("pid_torque_with_feedforward_clamp_top test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_mode m;
        i_rst_n                    <= 1'b0;
        i_cfg_we                   <= 1'b0;
        i_cfg_idx                  <= CFG_KP;
        i_cfg_data                 <= '0;
        cmd_if.valid               <= 1'b0;
        cmd_if.mode                <= MODE_STEP;
        cmd_if.joint_index         <= '0;
        cmd_if.measured_position   <= '0;
        cmd_if.measured_velocity   <= '0;
        cmd_if.target_position     <= '0;
        cmd_if.target_velocity     <= '0;
        cmd_if.target_acceleration <= '0;
        calm = 1'b0;
        hold_req = 1'b0;
        n_settings = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero gains, unit ceiling, default tick
        send_cmd(make_cmd(MODE_STEP, 2'd0, Q_MIN32, Q_MIN32, Q_MAX32, Q_MAX32, Q_MAX32));
        send_cmd(make_cmd(MODE_STEP, 2'd1, Q_MAX32, Q_MAX32, Q_MIN32, Q_MIN32, Q_MIN32));
        send_cmd(make_cmd(MODE_STEP, 2'd2, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_CLR_INTEG, 2'd0, pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16()));
        send_cmd(make_cmd(MODE_RSVD, 2'd1, pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16()));
        send_cmd(make_cmd(MODE_CLR_CNT, 2'd2, pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16()));
        // every mode on a joint that does not exist
        m = m.first();
        do begin
            send_cmd(make_cmd(m, JOINT_OOR, pick_q16(), pick_q16(), pick_q16(),
                              pick_q16(), pick_q16()));
            m = m.next();
        end while (m != m.first());

        // all registers at their maximum
        wait_for_drain();
        write_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, TICK_MAX);
        send_cmd(make_cmd(MODE_STEP, 2'd0, Q_MIN32, Q_MIN32, Q_MAX32, Q_MAX32, Q_MAX32));
        send_cmd(make_cmd(MODE_STEP, 2'd1, Q_MAX32, Q_MAX32, Q_MIN32, Q_MIN32, Q_MIN32));
        send_cmd(make_cmd(MODE_STEP, 2'd2, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_STEP, 2'd0, Q_MIN32, Q_MIN32, Q_MAX32, Q_MAX32, Q_MAX32));

        // zero ceiling and zero tick: always at the limit, integral frozen
        wait_for_drain();
        write_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(), '0, '0);
        send_cmd(make_cmd(MODE_STEP, 2'd0, pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16()));
        send_cmd(make_cmd(MODE_STEP, 2'd0, pick_q16(), pick_q16(), pick_q16(),
                          pick_q16(), pick_q16()));

        // unit kp only, so torque equals the position error: 0.98 threshold
        wait_for_drain();
        write_config(ONE_Q16, '0, '0, '0, 31'd50000, TICK_RST);
        send_cmd(make_cmd(MODE_STEP, 2'd1, 0, 0, 32'sd49000, 0, 0));
        send_cmd(make_cmd(MODE_STEP, 2'd1, 0, 0, 32'sd48999, 0, 0));
        send_cmd(make_cmd(MODE_STEP, 2'd2, 0, 0, -32'sd49000, 0, 0));
        send_cmd(make_cmd(MODE_STEP, 2'd2, 0, 0, -32'sd48999, 0, 0));
        send_cmd(make_cmd(MODE_STEP, 2'd0, 0, 0, Q_MAX32, 0, 0));

        for (int s = 0; s < RAND_SETTINGS; s++) begin
            wait_for_drain();
            write_config(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                         pick_ceiling(), pick_tick());
            if (s == 2) hold_req = 1'b1;
            for (int i = 0; i < RAND_ITEMS; i++) send_cmd(random_cmd());
        end

        // wind-up: joint 0 driven by full positive error, joint 1 by full negative
        wait_for_drain();
        calm = 1'b1;
        write_config(pick_gain(), 31'd1, pick_gain(), pick_gain(), GAIN_MAX, TICK_MAX);
        send_cmd(make_cmd(MODE_CLR_INTEG, 2'd0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(MODE_CLR_INTEG, 2'd1, 0, 0, 0, 0, 0));
        for (int i = 0; i < 2 * WINDUP_STEPS; i++) begin
            if (i % 2 == 0)
                send_cmd(make_cmd(MODE_STEP, 2'd0, Q_MIN32, pick_q16(), Q_MAX32,
                                  pick_q16(), pick_q16()));
            else
                send_cmd(make_cmd(MODE_STEP, 2'd1, Q_MAX32, pick_q16(), Q_MIN32,
                                  pick_q16(), pick_q16()));
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d control steps, %0d clears, %0d reserved or unknown-joint items",
                 torque_chk.n_steps, torque_chk.n_clears, torque_chk.n_other);
        $display("%0d items at the torque limit over %0d register settings, with a long stall",
                 torque_chk.n_at_limit, n_settings);
        if (torque_chk.mismatches == 0 && torque_chk.outstanding() == 0)
            $display("pid_torque_with_feedforward_clamp_top test passed");
        else
            $display("pid_torque_with_feedforward_clamp_top test failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/ptfc_pkg.sv
src/ptfc_cmd_if.sv
src/ptfc_res_if.sv
src/pid_torque_with_feedforward_clamp_top.sv
tb/ptfc_torque_check_pkg.sv
tb/pid_torque_with_feedforward_clamp_top_test.sv
